// File: src/dihedral_angle_from_positions_macros.svh
// ---------------------------------------------------------------------------
// Dihedral angle unit: assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef DIHEDRAL_ANGLE_FROM_POSITIONS_MACROS_SVH
`define DIHEDRAL_ANGLE_FROM_POSITIONS_MACROS_SVH

// same-cycle implication
`define DAP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dihedral unit check failed");

// next-cycle implication
`define DAP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dihedral unit check failed");

`endif

// File: src/dap_pkg.sv
// ---------------------------------------------------------------------------
// Dihedral angle unit: package
// Widths, micro-op types and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none

package dap_pkg;

	localparam int ATOM_COUNT = 256;
	localparam int ATOM_W     = $clog2(ATOM_COUNT);
	localparam int IDX_W      = 8;
	localparam int COORD_W    = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int VEC_W      = 21;
	localparam int T_W        = 42;
	localparam int MUL_A_W    = 45;
	localparam int MUL_B_W    = 23;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int CHUNK_W    = 22;
	localparam int ACC_W      = 96;
	localparam int LEN_W      = 42;
	localparam int DS_W       = 64;
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int CORD_BITS  = 30;
	localparam int CORD_STEPS = 30;
	localparam int CX_W       = 33;
	localparam int CZ_W       = 32;
	localparam int ANG_W      = 23;
	localparam int DEG_W      = 25;
	localparam int DEG90_Q24  = 1509949440;
	localparam int DEG180_Q16 = 11796480;

	typedef enum logic [3:0] {
		DST_NONE, DST_T0X, DST_T0Y, DST_T0Z, DST_T1X, DST_T1Y, DST_T1Z,
		DST_LEN, DST_CW, DST_DS, DST_SW
	} dest_t;

	typedef struct packed {
		logic                        valid;
		logic signed [MUL_A_W-1:0]   a;
		logic signed [MUL_B_W-1:0]   b;
		logic [1:0]                  k;
		logic                        neg;
		logic                        first;
		logic                        last;
		dest_t                       dest;
	} mac_op_t;

	typedef struct packed {
		logic                      valid;
		dest_t                     dest;
		logic signed [ACC_W-1:0]   value;
	} mac_res_t;

	// atan(2^-i) in degrees, Q.24
	function automatic logic [29:0] atan_q24(input logic [4:0] i);
		case (i)
			5'd0:  return 30'd754974720;
			5'd1:  return 30'd445687602;
			5'd2:  return 30'd235489088;
			5'd3:  return 30'd119537938;
			5'd4:  return 30'd60000934;
			5'd5:  return 30'd30029717;
			5'd6:  return 30'd15018523;
			5'd7:  return 30'd7509720;
			5'd8:  return 30'd3754917;
			5'd9:  return 30'd1877466;
			5'd10: return 30'd938734;
			5'd11: return 30'd469367;
			5'd12: return 30'd234684;
			5'd13: return 30'd117342;
			5'd14: return 30'd58671;
			5'd15: return 30'd29335;
			5'd16: return 30'd14668;
			5'd17: return 30'd7334;
			5'd18: return 30'd3667;
			5'd19: return 30'd1833;
			5'd20: return 30'd917;
			5'd21: return 30'd458;
			5'd22: return 30'd229;
			5'd23: return 30'd115;
			5'd24: return 30'd57;
			5'd25: return 30'd29;
			5'd26: return 30'd14;
			5'd27: return 30'd7;
			5'd28: return 30'd4;
			5'd29: return 30'd2;
			default: return 30'd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: src/dihedral_angle_from_positions.sv
// ---------------------------------------------------------------------------
// Dihedral angle from positions
// Atom coordinate store with a torsion angle query engine.
// ---------------------------------------------------------------------------
// Write item: result-free; next item accepted the following cycle.
// Query item: the time from accept to result is set by the 32-step
// square root that gates the sine product, the scaling shifts and the
// 30-step CORDIC. One item in flight; s_tready is high only while idle.
// arst_n clears control and the output valid; store contents are unknown
// until written.
`default_nettype none

`include "dihedral_angle_from_positions_macros.svh"

module dihedral_angle_from_positions (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// atom_index, coord_x, coord_y, coord_z, first_atom, second_atom,
	// third_atom, fourth_atom
	input  wire logic [135:0] s_tdata,
	// req_type
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// dihedral_deg, zero padded
	output logic [31:0]       m_tdata
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_FETCH, ST_DIFF, ST_NORM, ST_MAC, ST_DRAIN,
		ST_PREP, ST_SCALE, ST_CORDIC, ST_DONE
	} state_t;

	localparam logic [4:0] OP_S_FIRST = 5'd24;
	localparam logic [4:0] OP_LAST    = 5'd26;

	logic [dap_pkg::IDX_W-1:0]         atom_index;
	logic signed [dap_pkg::COORD_W-1:0] coord_x, coord_y, coord_z;
	logic [dap_pkg::IDX_W-1:0]         atom_f [4];
	logic                              req_type;

	state_t                            state_q;
	logic [4:0]                        cnt_q;
	logic                              sq_ok_q;
	logic                              rd_ok_q;
	logic                              cneg_q, sneg_q;
	logic [dap_pkg::IDX_W-1:0]         atom_q [4];
	logic signed [dap_pkg::COORD_W-1:0] p_q [12];
	logic signed [dap_pkg::DIFF_W-1:0] d_q [9];
	logic signed [dap_pkg::VEC_W-1:0]  r_q [9];
	logic signed [dap_pkg::T_W-1:0]    t0_q [3];
	logic signed [dap_pkg::T_W-1:0]    t1_q [3];
	logic signed [dap_pkg::ACC_W-1:0]  cw_q, sw_q;
	logic signed [dap_pkg::DS_W-1:0]   ds_q;
	logic [dap_pkg::ROOT_W-1:0]        lq_q;
	logic [dap_pkg::ACC_W-1:0]         cm_q, sm_q;
	logic [31:0]                       tdata_q;
	logic                              tvalid_q;

	logic                              accept;
	logic                              wr_en;
	logic [dap_pkg::ATOM_W-1:0]        waddr, raddr;
	logic [dap_pkg::IDX_W-1:0]         rd_atom;
	logic [dap_pkg::COORD_W-1:0]       rx, ry, rz;
	logic [1:0]                        fidx;
	logic [62:0]                       nv;
	dap_pkg::mac_op_t                  mop;
	dap_pkg::mac_res_t                 mres;
	logic                              sq_done;
	logic [dap_pkg::ROOT_W-1:0]        sq_root;
	logic                              cord_start, cord_done;
	logic [dap_pkg::ANG_W-1:0]         cord_ang;
	logic [dap_pkg::ACC_W-1:0]         top_mag;
	logic                              scale_end;
	logic signed [dap_pkg::DEG_W-1:0]  ang_u, ang_c, ang_f;
	logic                              out_free;

	assign req_type   = s_tuser[0];
	assign atom_index = s_tdata[7:0];
	assign coord_x    = s_tdata[39:8];
	assign coord_y    = s_tdata[71:40];
	assign coord_z    = s_tdata[103:72];
	assign atom_f[0]  = s_tdata[111:104];
	assign atom_f[1]  = s_tdata[119:112];
	assign atom_f[2]  = s_tdata[127:120];
	assign atom_f[3]  = s_tdata[135:128];

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign wr_en    = accept && !req_type && (32'(atom_index) < dap_pkg::ATOM_COUNT);
	assign waddr    = dap_pkg::ATOM_W'(atom_index);
	assign rd_atom  = atom_q[cnt_q[1:0]];
	assign raddr    = dap_pkg::ATOM_W'(rd_atom);
	assign fidx     = 2'(cnt_q - 5'd1);
	assign out_free = !tvalid_q || m_tready;

	dap_ram #(.WIDTH(dap_pkg::COORD_W), .DEPTH(dap_pkg::ATOM_COUNT)) u_x_store (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata(coord_x), .raddr(raddr), .rdata(rx)
	);
	dap_ram #(.WIDTH(dap_pkg::COORD_W), .DEPTH(dap_pkg::ATOM_COUNT)) u_y_store (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata(coord_y), .raddr(raddr), .rdata(ry)
	);
	dap_ram #(.WIDTH(dap_pkg::COORD_W), .DEPTH(dap_pkg::ATOM_COUNT)) u_z_store (
		.clk(clk), .we(wr_en), .waddr(waddr), .wdata(coord_z), .raddr(raddr), .rdata(rz)
	);

	function automatic logic [62:0] norm_vec(input logic signed [32:0] a,
			input logic signed [32:0] b, input logic signed [32:0] c);
		logic [32:0] ma, mb, mc, mx, sa, sb, sc;
		logic [5:0]  bl;
		logic [20:0] na, nb, nc;
		ma = a[32] ? 33'(-a) : 33'(a);
		mb = b[32] ? 33'(-b) : 33'(b);
		mc = c[32] ? 33'(-c) : 33'(c);
		mx = (ma > mb) ? ma : mb;
		mx = (mc > mx) ? mc : mx;
		bl = '0;
		for (int i = 0; i < 33; i++) begin
			if (mx[i]) bl = 6'(i + 1);
		end
		if (bl > 6'd20) begin
			sa = ma >> (bl - 6'd20);
			sb = mb >> (bl - 6'd20);
			sc = mc >> (bl - 6'd20);
		end else begin
			sa = ma << (6'd20 - bl);
			sb = mb << (6'd20 - bl);
			sc = mc << (6'd20 - bl);
		end
		na = a[32] ? 21'd0 - {1'b0, sa[19:0]} : {1'b0, sa[19:0]};
		nb = b[32] ? 21'd0 - {1'b0, sb[19:0]} : {1'b0, sb[19:0]};
		nc = c[32] ? 21'd0 - {1'b0, sc[19:0]} : {1'b0, sc[19:0]};
		return {na, nb, nc};
	endfunction

	function automatic dap_pkg::mac_op_t mk(input logic signed [44:0] a,
			input logic signed [22:0] b, input logic [1:0] k, input logic neg,
			input logic first, input logic last, input dap_pkg::dest_t dest);
		dap_pkg::mac_op_t o;
		o.valid = 1'b1;
		o.a     = a;
		o.b     = b;
		o.k     = k;
		o.neg   = neg;
		o.first = first;
		o.last  = last;
		o.dest  = dest;
		return o;
	endfunction

	function automatic logic signed [22:0] lo_chunk(input logic [21:0] v);
		return $signed({1'b0, v});
	endfunction

	function automatic logic signed [22:0] hi_chunk(input logic [19:0] v);
		return 23'($signed(v));
	endfunction

	assign nv = norm_vec(d_q[3 * int'(cnt_q[1:0])], d_q[3 * int'(cnt_q[1:0]) + 1],
		d_q[3 * int'(cnt_q[1:0]) + 2]);

	always_comb begin
		mop = '0;
		case (cnt_q)
			5'd0:  mop = mk(45'(r_q[1]), 23'(r_q[5]), 2'd0, 1'b0, 1'b1, 1'b0, dap_pkg::DST_NONE);
			5'd1:  mop = mk(45'(r_q[2]), 23'(r_q[4]), 2'd0, 1'b1, 1'b0, 1'b1, dap_pkg::DST_T0X);
			5'd2:  mop = mk(45'(r_q[2]), 23'(r_q[3]), 2'd0, 1'b0, 1'b1, 1'b0, dap_pkg::DST_NONE);
			5'd3:  mop = mk(45'(r_q[0]), 23'(r_q[5]), 2'd0, 1'b1, 1'b0, 1'b1, dap_pkg::DST_T0Y);
			5'd4:  mop = mk(45'(r_q[0]), 23'(r_q[4]), 2'd0, 1'b0, 1'b1, 1'b0, dap_pkg::DST_NONE);
			5'd5:  mop = mk(45'(r_q[1]), 23'(r_q[3]), 2'd0, 1'b1, 1'b0, 1'b1, dap_pkg::DST_T0Z);
			5'd6:  mop = mk(45'(r_q[7]), 23'(r_q[5]), 2'd0, 1'b0, 1'b1, 1'b0, dap_pkg::DST_NONE);
			5'd7:  mop = mk(45'(r_q[8]), 23'(r_q[4]), 2'd0, 1'b1, 1'b0, 1'b1, dap_pkg::DST_T1X);
			5'd8:  mop = mk(45'(r_q[8]), 23'(r_q[3]), 2'd0, 1'b0, 1'b1, 1'b0, dap_pkg::DST_NONE);
			5'd9:  mop = mk(45'(r_q[6]), 23'(r_q[5]), 2'd0, 1'b1, 1'b0, 1'b1, dap_pkg::DST_T1Y);
			5'd10: mop = mk(45'(r_q[6]), 23'(r_q[4]), 2'd0, 1'b0, 1'b1, 1'b0, dap_pkg::DST_NONE);
			5'd11: mop = mk(45'(r_q[7]), 23'(r_q[3]), 2'd0, 1'b1, 1'b0, 1'b1, dap_pkg::DST_T1Z);
			5'd12: mop = mk(45'(r_q[3]), 23'(r_q[3]), 2'd0, 1'b0, 1'b1, 1'b0, dap_pkg::DST_NONE);
			5'd13: mop = mk(45'(r_q[4]), 23'(r_q[4]), 2'd0, 1'b0, 1'b0, 1'b0, dap_pkg::DST_NONE);
			5'd14: mop = mk(45'(r_q[5]), 23'(r_q[5]), 2'd0, 1'b0, 1'b0, 1'b1, dap_pkg::DST_LEN);
			5'd15: mop = mk(45'(t0_q[0]), lo_chunk(t1_q[0][21:0]), 2'd0, 1'b0, 1'b1, 1'b0,
				dap_pkg::DST_NONE);
			5'd16: mop = mk(45'(t0_q[0]), hi_chunk(t1_q[0][41:22]), 2'd1, 1'b0, 1'b0, 1'b0,
				dap_pkg::DST_NONE);
			5'd17: mop = mk(45'(t0_q[1]), lo_chunk(t1_q[1][21:0]), 2'd0, 1'b0, 1'b0, 1'b0,
				dap_pkg::DST_NONE);
			5'd18: mop = mk(45'(t0_q[1]), hi_chunk(t1_q[1][41:22]), 2'd1, 1'b0, 1'b0, 1'b0,
				dap_pkg::DST_NONE);
			5'd19: mop = mk(45'(t0_q[2]), lo_chunk(t1_q[2][21:0]), 2'd0, 1'b0, 1'b0, 1'b0,
				dap_pkg::DST_NONE);
			5'd20: mop = mk(45'(t0_q[2]), hi_chunk(t1_q[2][41:22]), 2'd1, 1'b0, 1'b0, 1'b1,
				dap_pkg::DST_CW);
			5'd21: mop = mk(45'(t1_q[0]), 23'(r_q[0]), 2'd0, 1'b0, 1'b1, 1'b0, dap_pkg::DST_NONE);
			5'd22: mop = mk(45'(t1_q[1]), 23'(r_q[1]), 2'd0, 1'b0, 1'b0, 1'b0, dap_pkg::DST_NONE);
			5'd23: mop = mk(45'(t1_q[2]), 23'(r_q[2]), 2'd0, 1'b0, 1'b0, 1'b1, dap_pkg::DST_DS);
			5'd24: mop = mk($signed({13'd0, lq_q}), lo_chunk(ds_q[21:0]), 2'd0, 1'b0, 1'b1, 1'b0,
				dap_pkg::DST_NONE);
			5'd25: mop = mk($signed({13'd0, lq_q}), lo_chunk(ds_q[43:22]), 2'd1, 1'b0, 1'b0, 1'b0,
				dap_pkg::DST_NONE);
			5'd26: mop = mk($signed({13'd0, lq_q}), hi_chunk(ds_q[63:44]), 2'd2, 1'b0, 1'b0, 1'b1,
				dap_pkg::DST_SW);
			default: mop = '0;
		endcase
		if (state_q != ST_MAC || (cnt_q >= OP_S_FIRST && !sq_ok_q)) begin
			mop.valid = 1'b0;
		end
	end

	dap_mac u_mac (
		.clk(clk), .arst_n(arst_n), .op(mop), .res(mres)
	);

	dap_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n),
		.start(mres.valid && mres.dest == dap_pkg::DST_LEN),
		.rad(dap_pkg::RAD_W'(mres.value[dap_pkg::LEN_W-1:0]) << 20),
		.done(sq_done), .root(sq_root)
	);

	assign top_mag   = cm_q | sm_q;
	assign scale_end = (top_mag == '0) ||
		(!(|top_mag[dap_pkg::ACC_W-1:30]) && (|top_mag[dap_pkg::ACC_W-1:22]) && top_mag[29]);
	assign cord_start = state_q == ST_SCALE && scale_end;

	dap_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start),
		.x_in(cm_q[dap_pkg::CORD_BITS-1:0]), .y_in(sm_q[dap_pkg::CORD_BITS-1:0]),
		.done(cord_done), .ang(cord_ang)
	);

	always_comb begin
		ang_u = $signed({2'b00, cord_ang});
		ang_c = cneg_q ? dap_pkg::DEG_W'(dap_pkg::DEG180_Q16) - ang_u : ang_u;
		ang_f = sneg_q ? -ang_c : ang_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			sq_ok_q  <= 1'b0;
			tvalid_q <= 1'b0;
			tdata_q  <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
			if (sq_done) begin
				sq_ok_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && req_type) begin
						state_q <= ST_FETCH;
						cnt_q   <= '0;
						sq_ok_q <= 1'b0;
					end
				end
				ST_FETCH: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd4) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_NORM;
					cnt_q   <= '0;
				end
				ST_NORM: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd2) begin
						state_q <= ST_MAC;
						cnt_q   <= '0;
					end
				end
				ST_MAC: begin
					if (mop.valid) begin
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == OP_LAST) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: state_q <= ST_PREP;
				ST_PREP:  state_q <= ST_SCALE;
				ST_SCALE: begin
					if (scale_end) begin
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (cord_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						tdata_q  <= {7'd0, ang_f};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 4; i++) begin
				atom_q[i] <= atom_f[i];
			end
		end
		rd_ok_q <= 32'(rd_atom) < dap_pkg::ATOM_COUNT;
		if (state_q == ST_FETCH && cnt_q != 5'd0) begin
			p_q[3 * int'(fidx)]     <= rd_ok_q ? rx : '0;
			p_q[3 * int'(fidx) + 1] <= rd_ok_q ? ry : '0;
			p_q[3 * int'(fidx) + 2] <= rd_ok_q ? rz : '0;
		end
		if (state_q == ST_DIFF) begin
			for (int j = 0; j < 3; j++) begin
				d_q[j]     <= dap_pkg::DIFF_W'(p_q[j]) - dap_pkg::DIFF_W'(p_q[3 + j]);
				d_q[3 + j] <= dap_pkg::DIFF_W'(p_q[6 + j]) - dap_pkg::DIFF_W'(p_q[3 + j]);
				d_q[6 + j] <= dap_pkg::DIFF_W'(p_q[9 + j]) - dap_pkg::DIFF_W'(p_q[6 + j]);
			end
		end
		if (state_q == ST_NORM) begin
			r_q[3 * int'(cnt_q[1:0])]     <= nv[62:42];
			r_q[3 * int'(cnt_q[1:0]) + 1] <= nv[41:21];
			r_q[3 * int'(cnt_q[1:0]) + 2] <= nv[20:0];
		end
		if (mres.valid) begin
			case (mres.dest)
				dap_pkg::DST_T0X: t0_q[0] <= mres.value[dap_pkg::T_W-1:0];
				dap_pkg::DST_T0Y: t0_q[1] <= mres.value[dap_pkg::T_W-1:0];
				dap_pkg::DST_T0Z: t0_q[2] <= mres.value[dap_pkg::T_W-1:0];
				dap_pkg::DST_T1X: t1_q[0] <= mres.value[dap_pkg::T_W-1:0];
				dap_pkg::DST_T1Y: t1_q[1] <= mres.value[dap_pkg::T_W-1:0];
				dap_pkg::DST_T1Z: t1_q[2] <= mres.value[dap_pkg::T_W-1:0];
				dap_pkg::DST_CW:  cw_q    <= mres.value;
				dap_pkg::DST_DS:  ds_q    <= mres.value[dap_pkg::DS_W-1:0];
				dap_pkg::DST_SW:  sw_q    <= mres.value;
				default: ;
			endcase
		end
		if (sq_done) begin
			lq_q <= sq_root;
		end
		if (state_q == ST_PREP) begin
			cneg_q <= cw_q[dap_pkg::ACC_W-1];
			sneg_q <= sw_q[dap_pkg::ACC_W-1];
			cm_q   <= (cw_q[dap_pkg::ACC_W-1] ? dap_pkg::ACC_W'(-cw_q) : dap_pkg::ACC_W'(cw_q)) << 10;
			sm_q   <= sw_q[dap_pkg::ACC_W-1] ? dap_pkg::ACC_W'(-sw_q) : dap_pkg::ACC_W'(sw_q);
		end else if (state_q == ST_SCALE && !scale_end) begin
			if (|top_mag[dap_pkg::ACC_W-1:38]) begin
				cm_q <= cm_q >> 8;
				sm_q <= sm_q >> 8;
			end else if (|top_mag[dap_pkg::ACC_W-1:30]) begin
				cm_q <= cm_q >> 1;
				sm_q <= sm_q >> 1;
			end else if (!(|top_mag[dap_pkg::ACC_W-1:22])) begin
				cm_q <= cm_q << 8;
				sm_q <= sm_q << 8;
			end else begin
				cm_q <= cm_q << 1;
				sm_q <= sm_q << 1;
			end
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;

	`DAP_ASSERT_NXT(a_query_busy, s_tvalid && s_tready && s_tuser[0], !s_tready)
	`DAP_ASSERT_IMP(a_cordic_state, cord_done, state_q == ST_CORDIC)
	`DAP_ASSERT_IMP(a_sine_drain, mres.valid && mres.dest == dap_pkg::DST_SW, state_q == ST_DRAIN)
	`DAP_ASSERT_IMP(a_angle_range, m_tvalid,
		($signed(m_tdata[24:0]) <= 25'sd11796480) && ($signed(m_tdata[24:0]) >= -25'sd11796480))

endmodule

`default_nettype wire

// File: src/dap_ram.sv
// ---------------------------------------------------------------------------
// Dihedral angle unit: coordinate store
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module dap_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: src/dap_mac.sv
// ---------------------------------------------------------------------------
// Dihedral angle unit: shared multiply-accumulate
// Registered 45x23 product, then a shifted add into a 96-bit accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

module dap_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dap_pkg::mac_op_t  op,
	output dap_pkg::mac_res_t      res
);

	logic signed [dap_pkg::PROD_W-1:0] prod_s1;
	logic                              valid_s1;
	logic [1:0]                        k_s1;
	logic                              neg_s1;
	logic                              first_s1;
	logic                              last_s1;
	dap_pkg::dest_t                    dest_s1;
	logic signed [dap_pkg::ACC_W-1:0]  acc_q;
	logic signed [dap_pkg::ACC_W-1:0]  ext;
	logic signed [dap_pkg::ACC_W-1:0]  shifted;
	logic signed [dap_pkg::ACC_W-1:0]  addend;
	logic signed [dap_pkg::ACC_W-1:0]  sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= op.a * op.b;
		k_s1     <= op.k;
		neg_s1   <= op.neg;
		first_s1 <= op.first;
		last_s1  <= op.last;
		dest_s1  <= op.dest;
		if (valid_s1) begin
			acc_q <= sum;
		end
	end

	always_comb begin
		ext = dap_pkg::ACC_W'(prod_s1);
		case (k_s1)
			2'd0:    shifted = ext;
			2'd1:    shifted = ext <<< dap_pkg::CHUNK_W;
			2'd2:    shifted = ext <<< (2 * dap_pkg::CHUNK_W);
			default: shifted = ext;
		endcase
		addend = neg_s1 ? -shifted : shifted;
		sum    = (first_s1 ? '0 : acc_q) + addend;
	end

	assign res.valid = valid_s1 && last_s1;
	assign res.dest  = dest_s1;
	assign res.value = sum;

endmodule

`default_nettype wire

// File: src/dap_isqrt.sv
// ---------------------------------------------------------------------------
// Dihedral angle unit: integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module dap_isqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [dap_pkg::RAD_W-1:0]    rad,
	output logic                              done,
	output logic [dap_pkg::ROOT_W-1:0]        root
);

	logic [dap_pkg::RAD_W-1:0]    rad_q;
	logic [33:0]                  rem_q;
	logic [dap_pkg::ROOT_W-1:0]   root_q;
	logic [4:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [35:0]                  rem2;
	logic [35:0]                  trial;
	logic                         take;

	assign rem2  = {rem_q, rad_q[dap_pkg::RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign take  = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(dap_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= take ? 34'(rem2 - trial) : 34'(rem2);
			root_q <= {root_q[dap_pkg::ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// File: src/dap_cordic.sv
// ---------------------------------------------------------------------------
// Dihedral angle unit: CORDIC arctangent
// Vectoring mode, one rotation per cycle, result in degrees Q.16, 0..90.
// ---------------------------------------------------------------------------
`default_nettype none

module dap_cordic (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [dap_pkg::CORD_BITS-1:0]     x_in,
	input  wire logic [dap_pkg::CORD_BITS-1:0]     y_in,
	output logic                                   done,
	output logic [dap_pkg::ANG_W-1:0]              ang
);

	logic signed [dap_pkg::CX_W-1:0] x_q;
	logic signed [dap_pkg::CX_W-1:0] y_q;
	logic signed [dap_pkg::CZ_W-1:0] z_q;
	logic [4:0]                      i_q;
	logic                            busy_q;
	logic                            done_q;
	logic [dap_pkg::ANG_W-1:0]       ang_q;
	logic [dap_pkg::CX_W-1:0]        ymag;
	logic [dap_pkg::CX_W-1:0]        ysh;
	logic signed [dap_pkg::CX_W-1:0] ys;
	logic signed [dap_pkg::CX_W-1:0] xs;
	logic signed [dap_pkg::CZ_W-1:0] at;
	logic signed [dap_pkg::CZ_W-1:0] zc;
	logic signed [dap_pkg::CZ_W-1:0] zr;

	always_comb begin
		ymag = y_q[dap_pkg::CX_W-1] ? dap_pkg::CX_W'(-y_q) : dap_pkg::CX_W'(y_q);
		ysh  = ymag >> i_q;
		ys   = y_q[dap_pkg::CX_W-1] ? -$signed(ysh) : $signed(ysh);
		xs   = x_q >>> i_q;
		at   = $signed({2'b00, dap_pkg::atan_q24(i_q)});
		if (z_q < 0) begin
			zc = '0;
		end else if (z_q > dap_pkg::DEG90_Q24) begin
			zc = dap_pkg::CZ_W'(dap_pkg::DEG90_Q24);
		end else begin
			zc = z_q;
		end
		zr = zc + 32'sd128;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(dap_pkg::CORD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= $signed({3'b000, x_in});
			y_q <= $signed({3'b000, y_in});
			z_q <= '0;
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else if (y_q < 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
		if (done_q) begin
			ang_q <= zr[30:8];
		end
	end

	assign done = done_q;
	assign ang  = done_q ? zr[30:8] : ang_q;

endmodule

`default_nettype wire
